/* sv/ll1p_pkg.sv */
// ll1p_pkg: shared types and constants for the table-driven ll(1) parser
`timescale 1ns / 1ps
`default_nettype none
package ll1p_pkg;

   // symbol and field widths
   localparam int SYM_W    = 6;
   localparam int TERM_W   = 5;
   localparam int PROD_W   = 8;
   localparam int LEN_W    = 4;
   localparam int SLOT_W   = 3;
   localparam int DEPTH_W  = 9;
   localparam int STEP_W   = 16;
   localparam int ENTRY_W  = 9;
   localparam int TBL_AW   = 10;
   localparam int TBL_DEPTH = 1024;

   // configuration reset values
   localparam logic [SYM_W-1:0]  START_RESET = 6'd32;
   localparam logic [STEP_W-1:0] LIMIT_RESET = 16'd5000;

   // configuration register indexes
   localparam logic CSR_START_SYMBOL = 1'b0;
   localparam logic CSR_STEP_LIMIT   = 1'b1;

   typedef enum logic [2:0] {
      CMD_START  = 3'd0,
      CMD_TOKEN  = 3'd1,
      CMD_TABLE  = 3'd2,
      CMD_RHS    = 3'd3,
      CMD_LEN    = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      STS_CONSUMED   = 3'd0,
      STS_ACCEPTED   = 3'd1,
      STS_AFTER_END  = 3'd2,
      STS_MISMATCH   = 3'd3,
      STS_NO_RULE    = 3'd4,
      STS_OVERFLOW   = 3'd5,
      STS_STEP_LIMIT = 3'd6,
      STS_ACK        = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      EXP_ZERO  = 2'd0,
      EXP_RDATA = 2'd1,
      EXP_TOS   = 2'd2
   } exp_sel_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_INIT1,
      ST_LOOP,
      ST_EVAL,
      ST_TBL,
      ST_LEN,
      ST_PUSH_RD,
      ST_PUSH_WR,
      ST_OVF
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic        latch;
      logic        clr_wr;
      logic        init0;
      logic        init1;
      logic        tos_load;
      logic        step_inc;
      logic        pop;
      logic        tbl_wr;
      logic        load_prod;
      logic        len_wr;
      logic        rhs_wr;
      logic        load_cnt;
      logic        rhs_rd;
      logic        push;
      logic        act_set;
      logic        act_clr;
      logic        rsp;
      status_type  rsp_status;
      exp_sel_type exp_sel;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      cmd_type cmd;
      logic    active;
      logic    clr_done;
      logic    top_zero;
      logic    step_hit;
      logic    tos_zero;
      logic    tos_term;
      logic    tos_match;
      logic    term_zero;
      logic    entry_valid;
      logic    cnt_zero;
      logic    stk_full;
   } dp_stat_type;

endpackage
`default_nettype wire

/* sv/ll1p_ram.sv */
// ll1p_ram: generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module ll1p_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

/* sv/ll1p_ctrl.sv */
// ll1p_ctrl: sequencer for commands, expansions and pushes
`timescale 1ns / 1ps
`default_nettype none
module ll1p_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire ll1p_pkg::dp_stat_type stat,
   output ll1p_pkg::ctrl_cmd_type     cmd
);
   ll1p_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ll1p_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.rsp_status = ll1p_pkg::STS_ACK;
      cmd.exp_sel = ll1p_pkg::EXP_ZERO;
      case (state_ff)
         ll1p_pkg::ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.clr_done) begin
               state_in = ll1p_pkg::ST_IDLE;
            end
         end
         ll1p_pkg::ST_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in = ll1p_pkg::ST_DECODE;
            end
         end
         ll1p_pkg::ST_DECODE: begin
            state_in = ll1p_pkg::ST_IDLE;
            case (stat.cmd)
               ll1p_pkg::CMD_START: begin
                  cmd.init0 = 1'b1;
                  state_in = ll1p_pkg::ST_INIT1;
               end
               ll1p_pkg::CMD_TOKEN: begin
                  if (stat.active) begin
                     state_in = ll1p_pkg::ST_LOOP;
                  end else begin
                     cmd.rsp = 1'b1;
                     cmd.rsp_status = ll1p_pkg::STS_AFTER_END;
                  end
               end
               ll1p_pkg::CMD_TABLE: begin
                  cmd.tbl_wr = 1'b1;
                  cmd.rsp = 1'b1;
               end
               ll1p_pkg::CMD_RHS: begin
                  cmd.rhs_wr = 1'b1;
                  cmd.rsp = 1'b1;
               end
               ll1p_pkg::CMD_LEN: begin
                  cmd.len_wr = 1'b1;
                  cmd.rsp = 1'b1;
               end
               default: begin
                  cmd.rsp = 1'b1;
               end
            endcase
         end
         ll1p_pkg::ST_INIT1: begin
            cmd.init1 = 1'b1;
            cmd.act_set = 1'b1;
            cmd.rsp = 1'b1;
            state_in = ll1p_pkg::ST_IDLE;
         end
         ll1p_pkg::ST_LOOP: begin
            if (stat.top_zero) begin
               cmd.rsp = 1'b1;
               cmd.rsp_status = ll1p_pkg::STS_ACCEPTED;
               cmd.act_clr = 1'b1;
               state_in = ll1p_pkg::ST_IDLE;
            end else begin
               state_in = ll1p_pkg::ST_EVAL;
            end
         end
         ll1p_pkg::ST_EVAL: begin
            cmd.tos_load = 1'b1;
            state_in = ll1p_pkg::ST_IDLE;
            if (stat.step_hit) begin
               cmd.rsp = 1'b1;
               cmd.rsp_status = ll1p_pkg::STS_STEP_LIMIT;
               cmd.exp_sel = ll1p_pkg::EXP_RDATA;
               cmd.act_clr = 1'b1;
            end else begin
               cmd.step_inc = 1'b1;
               if (stat.tos_zero) begin
                  // end marker on top
                  cmd.rsp = 1'b1;
                  cmd.act_clr = 1'b1;
                  cmd.rsp_status = stat.term_zero ? ll1p_pkg::STS_ACCEPTED
                                                  : ll1p_pkg::STS_MISMATCH;
               end else if (stat.tos_term) begin
                  cmd.rsp = 1'b1;
                  if (stat.tos_match) begin
                     cmd.pop = 1'b1;
                     cmd.rsp_status = ll1p_pkg::STS_CONSUMED;
                  end else begin
                     cmd.rsp_status = ll1p_pkg::STS_MISMATCH;
                     cmd.exp_sel = ll1p_pkg::EXP_RDATA;
                     cmd.act_clr = 1'b1;
                  end
               end else begin
                  state_in = ll1p_pkg::ST_TBL;
               end
            end
         end
         ll1p_pkg::ST_TBL: begin
            if (stat.entry_valid) begin
               cmd.pop = 1'b1;
               cmd.load_prod = 1'b1;
               state_in = ll1p_pkg::ST_LEN;
            end else begin
               cmd.rsp = 1'b1;
               cmd.rsp_status = ll1p_pkg::STS_NO_RULE;
               cmd.exp_sel = ll1p_pkg::EXP_TOS;
               cmd.act_clr = 1'b1;
               state_in = ll1p_pkg::ST_IDLE;
            end
         end
         ll1p_pkg::ST_LEN: begin
            cmd.load_cnt = 1'b1;
            state_in = ll1p_pkg::ST_PUSH_RD;
         end
         ll1p_pkg::ST_PUSH_RD: begin
            if (stat.cnt_zero) begin
               state_in = ll1p_pkg::ST_LOOP;
            end else if (stat.stk_full) begin
               state_in = ll1p_pkg::ST_OVF;
            end else begin
               cmd.rhs_rd = 1'b1;
               state_in = ll1p_pkg::ST_PUSH_WR;
            end
         end
         ll1p_pkg::ST_PUSH_WR: begin
            cmd.push = 1'b1;
            state_in = ll1p_pkg::ST_PUSH_RD;
         end
         ll1p_pkg::ST_OVF: begin
            cmd.rsp = 1'b1;
            cmd.rsp_status = ll1p_pkg::STS_OVERFLOW;
            cmd.exp_sel = ll1p_pkg::EXP_RDATA;
            cmd.act_clr = 1'b1;
            state_in = ll1p_pkg::ST_IDLE;
         end
         default: begin
            state_in = ll1p_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ll1p_pkg::ST_IDLE);
endmodule
`default_nettype wire

/* sv/ll1p_dp.sv */
// ll1p_dp: stack, table and production stores with parse registers
`timescale 1ns / 1ps
`default_nettype none
module ll1p_dp #(
   parameter int STACK_DEPTH     = 256,
   parameter int MAX_RHS         = 8,
   parameter int NUM_PRODUCTIONS = 256
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire ll1p_pkg::ctrl_cmd_type       cmd,
   output ll1p_pkg::dp_stat_type             stat,
   input  wire logic [2:0]                   req_cmd,
   input  wire logic [ll1p_pkg::TERM_W-1:0]  req_terminal,
   input  wire logic [ll1p_pkg::SYM_W-1:0]   req_nonterminal,
   input  wire logic [ll1p_pkg::PROD_W-1:0]  req_production,
   input  wire logic                         req_entry_valid,
   input  wire logic [ll1p_pkg::SLOT_W-1:0]  req_slot,
   input  wire logic [ll1p_pkg::SYM_W-1:0]   req_symbol,
   input  wire logic [ll1p_pkg::LEN_W-1:0]   req_rhs_length,
   input  wire logic                         csr_we,
   input  wire logic                         csr_index,
   input  wire logic [ll1p_pkg::STEP_W-1:0]  csr_wdata,
   output logic                              rsp_valid,
   output logic [2:0]                        rsp_status,
   output logic [ll1p_pkg::SYM_W-1:0]        rsp_expected_symbol,
   output logic [ll1p_pkg::DEPTH_W-1:0]      rsp_depth
);
   localparam int SAW   = $clog2(STACK_DEPTH);
   localparam int TW    = $clog2(STACK_DEPTH + 1);
   localparam int PW    = $clog2(NUM_PRODUCTIONS);
   localparam int RHS_DEPTH = NUM_PRODUCTIONS * MAX_RHS;
   localparam int RAW   = $clog2(RHS_DEPTH);
   localparam int CW    = $clog2(MAX_RHS + 1);
   localparam int RECIP = (2**24 + NUM_PRODUCTIONS - 1) / NUM_PRODUCTIONS;

   // latched item fields
   logic [2:0]                       cmd_ff;
   logic [ll1p_pkg::TERM_W-1:0]      term_ff;
   logic [ll1p_pkg::SYM_W-1:0]       nt_ff;
   logic [ll1p_pkg::PROD_W-1:0]      prodin_ff;
   logic                             evalid_ff;
   logic [ll1p_pkg::SLOT_W-1:0]      slot_ff;
   logic [ll1p_pkg::SYM_W-1:0]       sym_ff;
   logic [ll1p_pkg::LEN_W-1:0]       len_ff;

   // parse state
   logic [TW-1:0]                    top_ff, top_in;
   logic [ll1p_pkg::STEP_W-1:0]      steps_ff;
   logic                             active_ff;
   logic [ll1p_pkg::SYM_W-1:0]       tos_ff;
   logic [PW-1:0]                    prod_ff;
   logic [CW-1:0]                    cnt_ff;
   logic [ll1p_pkg::TBL_AW-1:0]      clr_ff;
   logic [ll1p_pkg::SYM_W-1:0]       start_sym_ff;
   logic [ll1p_pkg::STEP_W-1:0]      limit_ff;

   // result registers
   logic                             rsp_valid_ff;
   logic [2:0]                       rsp_status_ff;
   logic [ll1p_pkg::SYM_W-1:0]       rsp_exp_ff;
   logic [ll1p_pkg::DEPTH_W-1:0]     rsp_depth_ff;

   // memory ports
   logic                             stk_we;
   logic [SAW-1:0]                   stk_waddr;
   logic [ll1p_pkg::SYM_W-1:0]       stk_wdata, stk_rdata;
   logic                             tbl_we;
   logic [ll1p_pkg::TBL_AW-1:0]      tbl_waddr, tbl_raddr;
   logic [ll1p_pkg::ENTRY_W-1:0]     tbl_wdata, tbl_rdata;
   logic [PW-1:0]                    len_raddr;
   logic [ll1p_pkg::LEN_W-1:0]       len_rdata;
   logic                             rhs_we;
   logic [RAW-1:0]                   rhs_waddr, rhs_raddr;
   logic [ll1p_pkg::SYM_W-1:0]       rhs_rdata;

   // production index reduced modulo the store size
   logic [31:0]                      p_ext, p_mul, p_quo, p_rem;
   logic [ll1p_pkg::PROD_W-1:0]      prod_red;
   logic [PW-1:0]                    prod_red_p;
   logic                             slot_ok;
   logic [CW-1:0]                    len_clip;
   logic [ll1p_pkg::SYM_W-1:0]       exp_val;

   always_comb begin
      p_ext = 32'(prodin_ff);
      p_mul = p_ext * 32'(RECIP);
      p_quo = p_mul >> 24;
      p_rem = p_ext - p_quo * 32'(NUM_PRODUCTIONS);
      prod_red = p_rem[ll1p_pkg::PROD_W-1:0];
      prod_red_p = PW'(p_rem);
   end

   assign slot_ok = (5'(slot_ff) < 5'(MAX_RHS));

   // length clipped to the right-hand side limit
   always_comb begin
      if (5'(len_rdata) > 5'(MAX_RHS)) begin
         len_clip = CW'(MAX_RHS);
      end else begin
         len_clip = CW'(len_rdata);
      end
   end

   // next stack pointer
   always_comb begin
      top_in = top_ff;
      if (cmd.init1) begin
         top_in = TW'(2);
      end else if (cmd.pop) begin
         top_in = top_ff - TW'(1);
      end else if (cmd.push) begin
         top_in = top_ff + TW'(1);
      end
   end

   // item capture and parse registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cmd_ff    <= req_cmd;
         term_ff   <= req_terminal;
         nt_ff     <= req_nonterminal;
         prodin_ff <= req_production;
         evalid_ff <= req_entry_valid;
         slot_ff   <= req_slot;
         sym_ff    <= req_symbol;
         len_ff    <= req_rhs_length;
      end
      if (cmd.tos_load) begin
         tos_ff <= stk_rdata;
      end
      if (cmd.load_prod) begin
         prod_ff <= PW'(tbl_rdata[ll1p_pkg::PROD_W-1:0]);
      end
      if (cmd.load_cnt) begin
         cnt_ff <= len_clip;
      end else if (cmd.rhs_rd) begin
         cnt_ff <= cnt_ff - CW'(1);
      end
   end

   // control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff       <= '0;
         steps_ff     <= '0;
         active_ff    <= 1'b0;
         clr_ff       <= '0;
         start_sym_ff <= ll1p_pkg::START_RESET;
         limit_ff     <= ll1p_pkg::LIMIT_RESET;
      end else begin
         top_ff <= top_in;
         if (cmd.init1) begin
            steps_ff <= '0;
         end else if (cmd.step_inc) begin
            steps_ff <= steps_ff + 16'd1;
         end
         if (cmd.act_set) begin
            active_ff <= 1'b1;
         end else if (cmd.act_clr) begin
            active_ff <= 1'b0;
         end
         if (cmd.clr_wr) begin
            clr_ff <= clr_ff + 10'd1;
         end
         if (csr_we) begin
            if (csr_index == ll1p_pkg::CSR_START_SYMBOL) begin
               start_sym_ff <= csr_wdata[ll1p_pkg::SYM_W-1:0];
            end else begin
               limit_ff <= csr_wdata;
            end
         end
      end
   end

   // expected symbol select
   always_comb begin
      case (cmd.exp_sel)
         ll1p_pkg::EXP_RDATA: exp_val = stk_rdata;
         ll1p_pkg::EXP_TOS:   exp_val = tos_ff;
         default:             exp_val = '0;
      endcase
   end

   // result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp;
      end
      if (cmd.rsp) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_exp_ff    <= exp_val;
         rsp_depth_ff  <= ll1p_pkg::DEPTH_W'(top_in);
      end
   end

   // symbol stack
   always_comb begin
      stk_we = cmd.init0 | cmd.init1 | cmd.push;
      if (cmd.init0) begin
         stk_waddr = '0;
         stk_wdata = '0;
      end else if (cmd.init1) begin
         stk_waddr = SAW'(1);
         stk_wdata = start_sym_ff;
      end else begin
         stk_waddr = SAW'(top_ff);
         stk_wdata = rhs_rdata;
      end
   end

   ll1p_ram #(.WIDTH(ll1p_pkg::SYM_W), .DEPTH(STACK_DEPTH)) u_stack (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .raddr (SAW'(top_ff - TW'(1))),
      .rdata (stk_rdata)
   );

   // prediction table, cleared after reset
   always_comb begin
      tbl_we = cmd.clr_wr | cmd.tbl_wr;
      if (cmd.clr_wr) begin
         tbl_waddr = clr_ff;
         tbl_wdata = '0;
      end else begin
         tbl_waddr = {nt_ff[ll1p_pkg::TERM_W-1:0], term_ff};
         tbl_wdata = {evalid_ff, prod_red};
      end
      tbl_raddr = {stk_rdata[ll1p_pkg::TERM_W-1:0], term_ff};
   end

   ll1p_ram #(.WIDTH(ll1p_pkg::ENTRY_W), .DEPTH(ll1p_pkg::TBL_DEPTH)) u_table (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (tbl_wdata),
      .raddr (tbl_raddr),
      .rdata (tbl_rdata)
   );

   // production lengths
   assign len_raddr = PW'(tbl_rdata[ll1p_pkg::PROD_W-1:0]);

   ll1p_ram #(.WIDTH(ll1p_pkg::LEN_W), .DEPTH(NUM_PRODUCTIONS)) u_lengths (
      .clock (clock),
      .we    (cmd.len_wr),
      .waddr (prod_red_p),
      .wdata (len_ff),
      .raddr (len_raddr),
      .rdata (len_rdata)
   );

   // right-hand side symbols
   assign rhs_we    = cmd.rhs_wr & slot_ok;
   assign rhs_waddr = RAW'(32'(prod_red_p) * 32'(MAX_RHS) + 32'(slot_ff));
   assign rhs_raddr = RAW'(32'(prod_ff) * 32'(MAX_RHS) + 32'(cnt_ff) - 32'd1);

   ll1p_ram #(.WIDTH(ll1p_pkg::SYM_W), .DEPTH(RHS_DEPTH)) u_rhs (
      .clock (clock),
      .we    (rhs_we),
      .waddr (rhs_waddr),
      .wdata (sym_ff),
      .raddr (rhs_raddr),
      .rdata (rhs_rdata)
   );

   // status to the controller
   always_comb begin
      stat.cmd         = ll1p_pkg::cmd_type'(cmd_ff);
      stat.active      = active_ff;
      stat.clr_done    = (clr_ff == '1);
      stat.top_zero    = (top_ff == '0);
      stat.step_hit    = (steps_ff >= limit_ff);
      stat.tos_zero    = (stk_rdata == '0);
      stat.tos_term    = ~stk_rdata[ll1p_pkg::SYM_W-1];
      stat.tos_match   = (stk_rdata == {1'b0, term_ff});
      stat.term_zero   = (term_ff == '0);
      stat.entry_valid = tbl_rdata[ll1p_pkg::ENTRY_W-1];
      stat.cnt_zero    = (cnt_ff == '0);
      stat.stk_full    = (top_ff == TW'(STACK_DEPTH));
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_expected_symbol = rsp_exp_ff;
   assign rsp_depth           = rsp_depth_ff;
endmodule
`default_nettype wire

/* sv/ll1_table_driven_parser.sv */
// ll1_table_driven_parser: top level of the ll(1) predictive parser
//
// An item is taken at a clock edge with start high and busy low; its fields
// come on the req_ ports. Each item gives one result, shown for one cycle
// on the rsp_ ports with rsp_valid high; the receiver cannot hold it off.
// A start command writes the end marker and the start symbol to the stack.
// A token passes through the stack loop (match, end marker test, expansion
// or step limit test) until it is consumed or the parse ends. An expansion
// reads the table entry and the rule length, then pushes the rule's symbols
// last first, with one read and one write per symbol; a full stack ends it
// with an overflow result. The stack, table and production stores have
// registered reads. busy is low again in the result cycle, so the next item
// can be taken at the edge that ends it.
// Configuration is written through csr_we, csr_index and csr_wdata with
// no wait; index 0 is the start symbol, index 1 the step limit.
// After reset the prediction table is cleared one entry a cycle, and busy
// stays high until all 1024 entries are clear; csr writes are taken then.
// Reset leaves no parse running and the configuration at its defaults.
`timescale 1ns / 1ps
`default_nettype none
module ll1_table_driven_parser #(
   parameter int STACK_DEPTH     = 256,
   parameter int MAX_RHS         = 8,
   parameter int NUM_PRODUCTIONS = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_cmd,
   input  wire logic [4:0]  req_terminal,
   input  wire logic [5:0]  req_nonterminal,
   input  wire logic [7:0]  req_production,
   input  wire logic        req_entry_valid,
   input  wire logic [2:0]  req_slot,
   input  wire logic [5:0]  req_symbol,
   input  wire logic [3:0]  req_rhs_length,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [5:0]       rsp_expected_symbol,
   output logic [8:0]       rsp_depth,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);
   ll1p_pkg::ctrl_cmd_type cmd;
   ll1p_pkg::dp_stat_type  stat;

   // sequencer
   ll1p_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // stores and parse registers
   ll1p_dp #(
      .STACK_DEPTH     (STACK_DEPTH),
      .MAX_RHS         (MAX_RHS),
      .NUM_PRODUCTIONS (NUM_PRODUCTIONS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_cmd             (req_cmd),
      .req_terminal        (req_terminal),
      .req_nonterminal     (req_nonterminal),
      .req_production      (req_production),
      .req_entry_valid     (req_entry_valid),
      .req_slot            (req_slot),
      .req_symbol          (req_symbol),
      .req_rhs_length      (req_rhs_length),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_expected_symbol (rsp_expected_symbol),
      .rsp_depth           (rsp_depth)
   );
endmodule
`default_nettype wire
